[src/rleisd_pkg.sv]
package rleisd_pkg;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_RUN    = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_MAGIC   = 2'd1;
   localparam logic [1:0] ERR_VERSION = 2'd2;
   localparam logic [1:0] ERR_MODE    = 2'd3;

   localparam logic [7:0] MODE_RLE    = 8'd1;

   typedef enum logic [1:0] {
      OP_HEADER,
      OP_ERROR,
      OP_WORD
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [1:0]  err;
      logic [15:0] word;
      logic [15:0] width;
      logic [15:0] height;
      logic [7:0]  mode;
   } entry_type;

endpackage

[src/rleisd_front.sv]
module rleisd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           data_byte,
   input  logic                 file_start,
   output logic                 push,
   output rleisd_pkg::entry_type push_data
);
   import rleisd_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_SKIP,
      PH_DATA,
      PH_HALT
   } phase_type;

   localparam logic [5:0][7:0] MagicBytes = {8'h36, 8'h31, 8'h4d, 8'h53, 8'h50, 8'h1b};
   localparam logic [7:0]      Version    = 8'd1;

   phase_type   phase_ff, phase_in, phase_cur;
   logic [3:0]  idx_ff, idx_in, idx_cur;
   logic [15:0] width_ff, width_in, width_cur;
   logic [15:0] height_ff, height_in, height_cur;
   logic [7:0]  mode_ff, mode_in, mode_cur;
   logic [7:0]  skip_ff, skip_in, skip_cur;
   logic [7:0]  low_ff, low_in, low_cur;
   logic        half_ff, half_in, half_cur;

   // a file start restarts parsing from the reset state
   always_comb begin
      if (file_start) begin
         phase_cur  = PH_HEADER;
         idx_cur    = '0;
         width_cur  = '0;
         height_cur = '0;
         mode_cur   = '0;
         skip_cur   = '0;
         low_cur    = '0;
         half_cur   = 1'b0;
      end else begin
         phase_cur  = phase_ff;
         idx_cur    = idx_ff;
         width_cur  = width_ff;
         height_cur = height_ff;
         mode_cur   = mode_ff;
         skip_cur   = skip_ff;
         low_cur    = low_ff;
         half_cur   = half_ff;
      end
   end

   always_comb begin
      phase_in  = phase_cur;
      idx_in    = idx_cur;
      width_in  = width_cur;
      height_in = height_cur;
      mode_in   = mode_cur;
      skip_in   = skip_cur;
      low_in    = low_cur;
      half_in   = half_cur;
      push      = 1'b0;
      push_data.kind   = OP_WORD;
      push_data.err    = ERR_NONE;
      push_data.word   = {data_byte, low_cur};
      push_data.width  = width_cur;
      push_data.height = height_cur;
      push_data.mode   = mode_cur;

      case (phase_cur)
         PH_HEADER: begin
            idx_in = idx_cur + 4'd1;
            if (idx_cur < 4'd6) begin
               if (data_byte != MagicBytes[idx_cur[2:0]]) begin
                  phase_in      = PH_HALT;
                  push          = 1'b1;
                  push_data.kind = OP_ERROR;
                  push_data.err  = ERR_MAGIC;
               end
            end else begin
               case (idx_cur)
                  4'd6: begin
                     if (data_byte != Version) begin
                        phase_in       = PH_HALT;
                        push           = 1'b1;
                        push_data.kind = OP_ERROR;
                        push_data.err  = ERR_VERSION;
                     end
                  end
                  4'd7:  width_in  = {8'h00, data_byte};
                  4'd8:  width_in  = {data_byte, width_cur[7:0]};
                  4'd9:  height_in = {8'h00, data_byte};
                  4'd10: height_in = {data_byte, height_cur[7:0]};
                  4'd11: mode_in   = data_byte;
                  default: begin
                     push = 1'b1;
                     if (mode_cur > MODE_RLE) begin
                        phase_in       = PH_HALT;
                        push_data.kind = OP_ERROR;
                        push_data.err  = ERR_MODE;
                     end else begin
                        push_data.kind = OP_HEADER;
                        skip_in  = (data_byte == 8'd0) ? 8'd0 : data_byte - 8'd1;
                        phase_in = (skip_in == 8'd0) ? PH_DATA : PH_SKIP;
                     end
                  end
               endcase
            end
         end
         PH_SKIP: begin
            skip_in = skip_cur - 8'd1;
            if (skip_in == 8'd0) begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            if (!half_cur) begin
               low_in  = data_byte;
               half_in = 1'b1;
            end else begin
               half_in = 1'b0;
               push    = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (!accept) begin
         push = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         idx_ff    <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         mode_ff   <= '0;
         skip_ff   <= '0;
         low_ff    <= '0;
         half_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         mode_ff   <= mode_in;
         skip_ff   <= skip_in;
         low_ff    <= low_in;
         half_ff   <= half_in;
      end
   end

endmodule

[src/rleisd_fifo.sv]
module rleisd_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rleisd_pkg::entry_type push_data,
   input  logic                  pop,
   output rleisd_pkg::entry_type pop_data,
   output logic                  empty,
   output logic                  full
);
   import rleisd_pkg::*;

   entry_type  mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign empty    = (count_ff == 2'd0);
   assign full     = (count_ff == 2'd2);
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[src/rleisd_back.sv]
module rleisd_back #(
   parameter int COUNT_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  empty,
   input  rleisd_pkg::entry_type entry,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_result_kind,
   output logic [15:0]           rsp_pixel_color,
   output logic [16:0]           rsp_run_length,
   output logic [15:0]           rsp_image_width,
   output logic [15:0]           rsp_image_height,
   output logic [7:0]            rsp_storage_mode,
   output logic [1:0]            rsp_error_code
);
   import rleisd_pkg::*;

   localparam int          CntBits   = (COUNT_BITS < 16) ? COUNT_BITS : 16;
   localparam logic [15:0] CountMask = 16'((32'd1 << CntBits) - 32'd1);
   localparam logic [16:0] CountMax  = 17'(32'd1 << CntBits);

   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [15:0] color_ff, color_in;
   logic [16:0] len_ff, len_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [7:0]  mode_ff, mode_in;
   logic [1:0]  err_ff, err_in;
   logic [15:0] last_ff, last_in;
   logic        have_ff, have_in;
   logic        await_ff, await_in;
   logic        emit;
   logic [15:0] masked;

   assign pop    = !empty && (!valid_ff || !rsp_stall);
   assign masked = entry.word & CountMask;

   always_comb begin
      emit      = 1'b0;
      kind_in   = KIND_RUN;
      color_in  = entry.word;
      len_in    = 17'd1;
      err_in    = ERR_NONE;
      width_in  = entry.width;
      height_in = entry.height;
      mode_in   = entry.mode;
      last_in   = last_ff;
      have_in   = have_ff;
      await_in  = await_ff;
      case (entry.kind)
         OP_HEADER: begin
            emit     = 1'b1;
            kind_in  = KIND_HEADER;
            color_in = '0;
            len_in   = '0;
            last_in  = '0;
            have_in  = 1'b0;
            await_in = 1'b0;
         end
         OP_ERROR: begin
            emit     = 1'b1;
            kind_in  = KIND_ERROR;
            color_in = '0;
            len_in   = '0;
            err_in   = entry.err;
         end
         OP_WORD: begin
            if (await_ff) begin
               emit     = 1'b1;
               await_in = 1'b0;
               color_in = last_ff;
               len_in   = (masked == 16'd0) ? CountMax : {1'b0, masked};
            end else if (entry.mode == MODE_RLE && have_ff && entry.word == last_ff) begin
               await_in = 1'b1;
            end else begin
               emit = 1'b1;
               if (entry.mode == MODE_RLE) begin
                  have_in = 1'b1;
                  last_in = entry.word;
               end
            end
         end
         default: begin
         end
      endcase
      if (pop) begin
         valid_in = emit;
      end else begin
         valid_in = valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         last_ff  <= '0;
         have_ff  <= 1'b0;
         await_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            last_ff  <= last_in;
            have_ff  <= have_in;
            await_ff <= await_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         kind_ff   <= kind_in;
         color_ff  <= color_in;
         len_ff    <= len_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         mode_ff   <= mode_in;
         err_ff    <= err_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_pixel_color  = color_ff;
   assign rsp_run_length   = len_ff;
   assign rsp_image_width  = width_ff;
   assign rsp_image_height = height_ff;
   assign rsp_storage_mode = mode_ff;
   assign rsp_error_code   = err_ff;

endmodule

[src/rle_image_stream_decoder.sv]
// Run-length image stream decoder, 16-bit pixels.
// Request channel: one file byte per request (req_data_byte); req_file_start
// marks the first byte of a file and restarts header parsing.
// Response channel: header info, pixel run or error per rsp_result_kind.
// Header bytes and the padding produce no response until the offset byte, which
// yields the header (or an unsupported-mode error); a bad magic or version byte
// yields its own error response. Data bytes pair into little-endian words; in
// run-length mode a repeated word plus a count word yields one run response.
// A response is registered: the request that completes it is written into the
// queue at the accepting edge, then moves to the output register once it is free.
// Throughput: one request per cycle while req_stall is low; the parser updates
// small registers only, and the two-entry queue and output register keep it fed.
// When the receiver holds rsp_stall, the output register holds its response,
// the queue fills and req_stall rises once both queue entries are taken.
// Reset (synchronous) clears parser, queue and run state and acts as the
// start of a file.
module rle_image_stream_decoder #(
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_file_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [15:0] rsp_pixel_color,
   output logic [16:0] rsp_run_length,
   output logic [15:0] rsp_image_width,
   output logic [15:0] rsp_image_height,
   output logic [7:0]  rsp_storage_mode,
   output logic [1:0]  rsp_error_code
);
   import rleisd_pkg::*;

   logic      accept;
   logic      push;
   logic      pop;
   logic      empty;
   logic      full;
   entry_type push_data;
   entry_type pop_data;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   rleisd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .file_start (req_file_start),
      .push       (push),
      .push_data  (push_data)
   );

   rleisd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty),
      .full      (full)
   );

   rleisd_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .empty            (empty),
      .entry            (pop_data),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_pixel_color  (rsp_pixel_color),
      .rsp_run_length   (rsp_run_length),
      .rsp_image_width  (rsp_image_width),
      .rsp_image_height (rsp_image_height),
      .rsp_storage_mode (rsp_storage_mode),
      .rsp_error_code   (rsp_error_code)
   );

endmodule

[dv/rle_image_stream_decoder_tb.sv]
module rle_image_stream_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rleisd_pkg::*;

   localparam int COUNT_BITS = 16;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_BYTES = 500;
   localparam logic [47:0] FILE_MAGIC = {8'h1b, 8'h50, 8'h53, 8'h4d, 8'h31, 8'h36};
   localparam logic [7:0] FILE_VERSION = 8'd1;
   localparam logic [7:0] MODE_RAW = 8'd0;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_SKIP,
      PH_DATA,
      PH_HALT
   } parse_phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] color;
      logic [16:0] len;
      logic [15:0] width;
      logic [15:0] height;
      logic [7:0]  mode;
      logic [1:0]  err;
   } decode_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_file_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [15:0] rsp_pixel_color;
   logic [16:0] rsp_run_length;
   logic [15:0] rsp_image_width;
   logic [15:0] rsp_image_height;
   logic [7:0]  rsp_storage_mode;
   logic [1:0]  rsp_error_code;

   decode_result_type expected_decodes[$];
   logic [7:0]        file_bytes[$];
   int                err_count = 0;
   int                idle_cycles = 0;
   int                bytes_sent = 0;
   bit                idle_on = 1'b0;
   bit                long_hold = 1'b0;

   // decoder state mirror
   parse_phase_type phase;
   logic [3:0]      hdr_idx;
   logic [15:0]     width_hold;
   logic [15:0]     height_hold;
   logic [7:0]      mode_hold;
   logic [7:0]      skip_left;
   logic [7:0]      low_hold;
   logic            high_half;
   logic [15:0]     prev_color;
   logic            have_pixel;
   logic            want_count;

   rle_image_stream_decoder #(
      .COUNT_BITS(COUNT_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_file_start(req_file_start),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_kind(rsp_result_kind),
      .rsp_pixel_color(rsp_pixel_color),
      .rsp_run_length(rsp_run_length),
      .rsp_image_width(rsp_image_width),
      .rsp_image_height(rsp_image_height),
      .rsp_storage_mode(rsp_storage_mode),
      .rsp_error_code(rsp_error_code)
   );

   always #1 clock = ~clock;

   function automatic void clear_decoder();
      phase = PH_HEADER;
      hdr_idx = 4'd0;
      width_hold = 16'd0;
      height_hold = 16'd0;
      mode_hold = 8'd0;
      skip_left = 8'd0;
      low_hold = 8'd0;
      high_half = 1'b0;
      prev_color = 16'd0;
      have_pixel = 1'b0;
      want_count = 1'b0;
   endfunction

   function automatic void push_result(logic [1:0] kind, logic [15:0] color,
                                       logic [16:0] len, logic [1:0] err);
      decode_result_type r;
      r.kind = kind;
      r.color = color;
      r.len = len;
      r.width = width_hold;
      r.height = height_hold;
      r.mode = mode_hold;
      r.err = err;
      expected_decodes.push_back(r);
   endfunction

   function automatic logic [16:0] run_from_count(logic [15:0] word);
      logic [16:0] mask;
      logic [16:0] c;
      mask = (COUNT_BITS < 16) ? ((17'd1 << COUNT_BITS) - 17'd1) : 17'h0ffff;
      c = {1'b0, word} & mask;
      return (c == 17'd0) ? mask + 17'd1 : c;
   endfunction

   function automatic void decode_byte(logic [7:0] b, logic fs);
      logic [3:0]  idx;
      logic [15:0] word;
      if (fs)
         clear_decoder();
      case (phase)
         PH_HEADER: begin
            idx = hdr_idx;
            hdr_idx = idx + 4'd1;
            if (idx < 4'd6) begin
               if (b != FILE_MAGIC[47 - 8 * idx -: 8]) begin
                  phase = PH_HALT;
                  push_result(KIND_ERROR, 16'd0, 17'd0, ERR_MAGIC);
               end
            end else if (idx == 4'd6) begin
               if (b != FILE_VERSION) begin
                  phase = PH_HALT;
                  push_result(KIND_ERROR, 16'd0, 17'd0, ERR_VERSION);
               end
            end else if (idx == 4'd7) begin
               width_hold = {8'd0, b};
            end else if (idx == 4'd8) begin
               width_hold[15:8] = b;
            end else if (idx == 4'd9) begin
               height_hold = {8'd0, b};
            end else if (idx == 4'd10) begin
               height_hold[15:8] = b;
            end else if (idx == 4'd11) begin
               mode_hold = b;
            end else if (mode_hold > MODE_RLE) begin
               phase = PH_HALT;
               push_result(KIND_ERROR, 16'd0, 17'd0, ERR_MODE);
            end else begin
               skip_left = (b == 8'd0) ? 8'd0 : b - 8'd1;
               phase = (skip_left == 8'd0) ? PH_DATA : PH_SKIP;
               push_result(KIND_HEADER, 16'd0, 17'd0, ERR_NONE);
            end
         end
         PH_SKIP: begin
            skip_left = skip_left - 8'd1;
            if (skip_left == 8'd0)
               phase = PH_DATA;
         end
         PH_DATA: begin
            if (!high_half) begin
               low_hold = b;
               high_half = 1'b1;
            end else begin
               high_half = 1'b0;
               word = {b, low_hold};
               if (want_count) begin
                  want_count = 1'b0;
                  push_result(KIND_RUN, prev_color, run_from_count(word), ERR_NONE);
               end else if (mode_hold == MODE_RLE && have_pixel && word == prev_color) begin
                  want_count = 1'b1;
               end else begin
                  if (mode_hold == MODE_RLE) begin
                     have_pixel = 1'b1;
                     prev_color = word;
                  end
                  push_result(KIND_RUN, word, 17'd1, ERR_NONE);
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      err_count++;
   endtask

   // response checker and watchdog
   always @(posedge clock) begin
      decode_result_type e;
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("rle_image_stream_decoder_tb: done, errors");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_decodes.size() == 0) begin
            report_mismatch("unexpected response kind", 32'(rsp_result_kind), 32'd0);
         end else begin
            e = expected_decodes.pop_front();
            if (rsp_result_kind !== e.kind)
               report_mismatch("result_kind", 32'(rsp_result_kind), 32'(e.kind));
            if (rsp_pixel_color !== e.color)
               report_mismatch("pixel_color", 32'(rsp_pixel_color), 32'(e.color));
            if (rsp_run_length !== e.len)
               report_mismatch("run_length", 32'(rsp_run_length), 32'(e.len));
            if (rsp_image_width !== e.width)
               report_mismatch("image_width", 32'(rsp_image_width), 32'(e.width));
            if (rsp_image_height !== e.height)
               report_mismatch("image_height", 32'(rsp_image_height), 32'(e.height));
            if (rsp_storage_mode !== e.mode)
               report_mismatch("storage_mode", 32'(rsp_storage_mode), 32'(e.mode));
            if (rsp_error_code !== e.err)
               report_mismatch("error_code", 32'(rsp_error_code), 32'(e.err));
         end
      end
   end

   // receiver back-pressure
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            n = gap_len();
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fs);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(0, 3) == 0)
         gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_file_start <= fs;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_byte(b, fs);
      bytes_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_decodes.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   function automatic void add_word(logic [15:0] w);
      file_bytes.push_back(w[7:0]);
      file_bytes.push_back(w[15:8]);
   endfunction

   function automatic void add_header(logic [7:0] ver, logic [15:0] w, logic [15:0] h,
                                      logic [7:0] mode, logic [7:0] offset);
      for (int i = 0; i < 6; i++)
         file_bytes.push_back(FILE_MAGIC[47 - 8 * i -: 8]);
      file_bytes.push_back(ver);
      add_word(w);
      add_word(h);
      file_bytes.push_back(mode);
      file_bytes.push_back(offset);
      for (int i = 1; i < offset; i++)
         file_bytes.push_back(8'($urandom));
   endfunction

   task automatic send_file(input bit with_start);
      for (int i = 0; i < file_bytes.size(); i++)
         send_byte(file_bytes[i], with_start && i == 0);
      file_bytes.delete();
   endtask

   task automatic test_no_start_after_reset();
      idle_on = 1'b0;
      add_header(FILE_VERSION, 16'h0000, 16'h0000, MODE_RAW, 8'd0);
      add_word(16'h0000);
      add_word(16'hffff);
      send_file(1'b0);
   endtask

   task automatic test_raw_extremes();
      idle_on = 1'b0;
      add_header(FILE_VERSION, 16'hffff, 16'hffff, MODE_RAW, 8'd1);
      add_word(16'h00ff);
      add_word(16'hff00);
      file_bytes.push_back(8'haa);
      send_file(1'b1);
   endtask

   task automatic test_rle_runs();
      idle_on = 1'b1;
      add_header(FILE_VERSION, 16'd320, 16'd240, MODE_RLE, 8'd3);
      add_word(16'h0000);
      add_word(16'h0000);
      add_word(16'h0000);
      add_word(16'h1234);
      add_word(16'h1234);
      add_word(16'hffff);
      add_word(16'h1234);
      add_word(16'h0001);
      add_word(16'h8000);
      add_word(16'h8001);
      send_file(1'b1);
   endtask

   task automatic test_header_errors();
      idle_on = 1'b1;
      for (int pos = 0; pos < 7; pos++) begin
         add_header(FILE_VERSION, 16'h0102, 16'h0304, MODE_RLE, 8'd0);
         file_bytes[pos] = file_bytes[pos] ^ 8'(1 << (pos % 8));
         add_word(16'h5555);
         send_file(1'b1);
      end
      add_header(8'd2, 16'h0a0b, 16'h0c0d, MODE_RAW, 8'd0);
      send_file(1'b1);
      add_header(FILE_VERSION, 16'h1111, 16'h2222, 8'd2, 8'd0);
      add_word(16'h3333);
      send_file(1'b1);
      add_header(FILE_VERSION, 16'h4444, 16'h5555, 8'hff, 8'hff);
      send_file(1'b1);
   endtask

   task automatic test_long_skip();
      idle_on = 1'b0;
      add_header(FILE_VERSION, 16'h00aa, 16'h0055, MODE_RLE, 8'hff);
      add_word(16'hbeef);
      add_word(16'hbeef);
      add_word(16'h0002);
      send_file(1'b1);
   endtask

   task automatic test_back_pressure();
      idle_on = 1'b0;
      add_header(FILE_VERSION, 16'd64, 16'd1, MODE_RAW, 8'd0);
      for (int i = 0; i < 40; i++)
         add_word(16'($urandom));
      long_hold = 1'b1;
      send_file(1'b1);
      wait_drained();
      add_header(FILE_VERSION, 16'd8, 16'd8, MODE_RLE, 8'd2);
      add_word(16'h0f0f);
      add_word(16'h0f0f);
      add_word(16'h0000);
      send_file(1'b1);
      wait_drained();
   endtask

   task automatic test_random_files();
      int          start;
      int          pick;
      int          nwords;
      logic [7:0]  mode;
      logic [7:0]  offset;
      logic [15:0] palette[3];
      logic [15:0] c;
      start = bytes_sent;
      while (bytes_sent - start < RANDOM_BYTES) begin
         idle_on = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         mode = ($urandom_range(0, 2) == 0) ? MODE_RAW : MODE_RLE;
         offset = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4));
         if (pick >= 88 && pick < 93)
            mode = 8'($urandom_range(2, 255));
         if (pick >= 97) begin
            for (int i = $urandom_range(1, 12); i > 0; i--)
               file_bytes.push_back(8'($urandom));
            send_file($urandom_range(0, 3) == 0);
         end else begin
            add_header(FILE_VERSION, 16'($urandom), 16'($urandom), mode, offset);
            if (pick >= 80 && pick < 88) begin
               pick = $urandom_range(0, 6);
               file_bytes[pick] = file_bytes[pick] ^ 8'($urandom_range(1, 255));
            end else if (pick >= 93) begin
               for (int i = $urandom_range(1, 12); i > 0; i--)
                  void'(file_bytes.pop_back());
            end
            for (int i = 0; i < 3; i++)
               palette[i] = 16'($urandom);
            nwords = $urandom_range(0, 30);
            for (int i = 0; i < nwords; i++) begin
               c = ($urandom_range(0, 4) == 0) ? 16'($urandom) : palette[$urandom_range(0, 2)];
               add_word(c);
               if (mode == MODE_RLE && $urandom_range(0, 2) == 0) begin
                  add_word(c);
                  case ($urandom_range(0, 4))
                     0: add_word(16'h0000);
                     1: add_word(16'h0001);
                     2: add_word(16'hffff);
                     default: add_word(16'($urandom));
                  endcase
               end
            end
            if ($urandom_range(0, 4) == 0)
               file_bytes.push_back(8'($urandom));
            send_file($urandom_range(0, 19) != 0);
         end
      end
   endtask

   initial begin
      clear_decoder();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_no_start_after_reset();
      test_raw_extremes();
      test_rle_runs();
      test_header_errors();
      test_long_skip();
      test_back_pressure();
      test_random_files();
      idle_on = 1'b0;
      wait_drained();
      repeat (8) @(posedge clock);
      if (err_count == 0 && expected_decodes.size() == 0)
         $display("rle_image_stream_decoder_tb: done, clean");
      else
         $display("rle_image_stream_decoder_tb: done, errors");
      $finish;
   end

endmodule

[filelist.f]
src/rleisd_pkg.sv
src/rleisd_front.sv
src/rleisd_fifo.sv
src/rleisd_back.sv
src/rle_image_stream_decoder.sv
dv/rle_image_stream_decoder_tb.sv
